/* hw/rtl/multi_waveform_oscillator_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the multi-waveform oscillator.
// Define NO_ASSERTIONS to compile every check away.
// ----------------------------------------------------------------------------
`ifndef MULTI_WAVEFORM_OSCILLATOR_DEFINES_SVH
`define MULTI_WAVEFORM_OSCILLATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Clocked check that is switched off while reset is asserted.
`define MWO_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define MWO_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MWO_ASSERT(label, prop, msg)
`define MWO_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

/* hw/rtl/mwo_pkg.sv */
// ----------------------------------------------------------------------------
// mwo_pkg
// Shared widths, codes and the quarter-wave sine generator function.
// ----------------------------------------------------------------------------
package mwo_pkg;

    localparam int PHASE_BITS_DEF     = 32;
    localparam int SINE_ADDR_BITS_DEF = 10;

    localparam int STEP_W      = 32;
    localparam int WAVE_W      = 2;
    localparam int SAMPLE_W    = 16;
    localparam int MAG_W       = 15;
    localparam int IN_TDATA_W  = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [MAG_W-1:0] AMP = 15'd30000;

    localparam logic [WAVE_W-1:0] WAVE_SINE   = 2'd0;
    localparam logic [WAVE_W-1:0] WAVE_SAW    = 2'd1;
    localparam logic [WAVE_W-1:0] WAVE_TRI    = 2'd2;
    localparam logic [WAVE_W-1:0] WAVE_SQUARE = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_PHASE_STEP = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WAVEFORM   = 1'd1;

    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned SINE_BIAS   = 64'd16;
    localparam longint unsigned AMP_L       = 64'd30000;

    // Magnitude of AMP*sin(theta) with theta = (pi/2) * r / 2^(addr_bits-2).
    // The angle is in Q30 and sin comes from a truncated Horner series.
    // Only ever called with constant arguments to build the table.
    function automatic logic [MAG_W-1:0] quarter_sine(input longint unsigned r,
                                                      input int addr_bits);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned m;
        x  = (r * HALF_PI_Q30) >> (addr_bits - 2);
        x2 = (x * x) >> 30;
        t  = Q30_ONE - x2 / 110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        m  = ((((x * t) >> 30) + SINE_BIAS) * AMP_L) >> 30;
        if (m > AMP_L)
        begin
            m = AMP_L;
        end
        return m[MAG_W-1:0];
    endfunction

endpackage

/* hw/rtl/mwo_sine_rom.sv */
// ----------------------------------------------------------------------------
// mwo_sine_rom
// Quarter-wave sine magnitude table with a registered read port.
// ----------------------------------------------------------------------------
module mwo_sine_rom
    import mwo_pkg::*;
#(
    parameter int ADDR_BITS = SINE_ADDR_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-2:0] rd_addr,
    output logic [MAG_W-1:0]     rd_data
);

    localparam int DEPTH = (2 ** (ADDR_BITS - 2)) + 1;

    logic [MAG_W-1:0] rom_tbl [DEPTH];
    logic [MAG_W-1:0] rd_data_reg;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_tbl
        assign rom_tbl[i] = quarter_sine(64'(i), ADDR_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= rom_tbl[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/multi_waveform_oscillator.sv */
// ----------------------------------------------------------------------------
// multi_waveform_oscillator
// Phase-accumulator oscillator giving sine, sawtooth, triangle or square.
// An accepted input beat goes through the middle stage to the output register.
// Throughput is one beat per cycle unless m_tready low stalls the output; the registered
// sine table read sets the middle stage, and the phase add closes in the input cycle.
// Reset clears the phase, the step, the waveform select and all valids.
// ----------------------------------------------------------------------------
`include "multi_waveform_oscillator_defines.svh"

module multi_waveform_oscillator
    import mwo_pkg::*;
#(
    parameter int PHASE_BITS     = PHASE_BITS_DEF,
    parameter int SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [0] restart, [7:1] zero

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [SAMPLE_W-1:0]    m_tdata    // [15:0] sample
);

    localparam int PW    = PHASE_BITS;
    localparam int DW    = PHASE_BITS + 1;
    localparam int TW    = PHASE_BITS + 2;
    localparam int QW    = SINE_ADDR_BITS - 2;
    localparam int RW    = SINE_ADDR_BITS - 1;
    localparam int PRODW = PHASE_BITS + MAG_W + 1;

    localparam logic [RW-1:0] QSIZE  = {1'b1, {QW{1'b0}}};
    localparam logic [DW-1:0] FULL_D = {1'b1, {PW{1'b0}}};
    localparam logic [TW-1:0] FULL_T = {2'b01, {PW{1'b0}}};

    logic [STEP_W-1:0] phase_step_reg;
    logic [WAVE_W-1:0] waveform_reg;
    logic [PW-1:0]     phase_acc_reg;
    logic [PW-1:0]     step_aligned;

    logic              accept;
    logic              out_ready;
    logic [PW-1:0]     ph_cur;
    logic [PW-1:0]     phase_next;

    logic [SINE_ADDR_BITS-1:0] sine_addr;
    logic [1:0]        quad;
    logic [RW-1:0]     r_raw;
    logic [RW-1:0]     rom_addr;
    logic [MAG_W-1:0]  rom_data;

    logic [DW-1:0]     u_tri;
    logic [DW-1:0]     u_sel;
    logic [TW-1:0]     twice;
    logic              twice_ge;
    logic [TW-1:0]     d_wide;
    logic              neg_next;

    logic              s1_valid_reg;
    logic [DW-1:0]     s1_d_reg;
    logic              s1_neg_reg;

    logic [PRODW-1:0]  prod;
    logic [MAG_W-1:0]  mag;
    logic signed [SAMPLE_W-1:0] mag_s;
    logic signed [SAMPLE_W-1:0] sample_next;

    logic                m_valid_reg;
    logic [SAMPLE_W-1:0] m_data_reg;

    if (PHASE_BITS >= STEP_W)
    begin : g_step_up
        assign step_aligned = PW'(phase_step_reg) << (PHASE_BITS - STEP_W);
    end
    else
    begin : g_step_down
        assign step_aligned = phase_step_reg[STEP_W-1 -: PHASE_BITS];
    end

    assign out_ready = !m_valid_reg || m_tready;
    assign s_tready  = !s1_valid_reg || out_ready;
    assign accept    = s_tvalid && s_tready;

    assign ph_cur     = s_tdata[0] ? '0 : phase_acc_reg;
    assign phase_next = ph_cur + step_aligned;

    assign sine_addr = ph_cur[PW-1 -: SINE_ADDR_BITS];
    assign quad      = sine_addr[SINE_ADDR_BITS-1 -: 2];
    assign r_raw     = {1'b0, sine_addr[QW-1:0]};
    assign rom_addr  = quad[0] ? (QSIZE - r_raw) : r_raw;

    assign u_tri    = ph_cur[PW-1] ? ((FULL_D - {1'b0, ph_cur}) << 1) : {ph_cur, 1'b0};
    assign u_sel    = (waveform_reg == WAVE_TRI) ? u_tri : {1'b0, ph_cur};
    assign twice    = {u_sel, 1'b0};
    assign twice_ge = (twice >= FULL_T);
    assign d_wide   = twice_ge ? (twice - FULL_T) : (FULL_T - twice);

    always_comb
    begin
        case (waveform_reg)
            WAVE_SINE:   neg_next = quad[1];
            WAVE_SQUARE: neg_next = ph_cur[PW-1];
            default:     neg_next = !twice_ge;
        endcase
    end

    mwo_sine_rom #(
        .ADDR_BITS (SINE_ADDR_BITS)
    ) u_sine_rom (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (rom_addr),
        .rd_data (rom_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= '0;
            waveform_reg   <= WAVE_SINE;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_PHASE_STEP: phase_step_reg <= cfg_data[STEP_W-1:0];
                CFG_WAVEFORM:   waveform_reg   <= cfg_data[WAVE_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg <= '0;
            s1_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_acc_reg <= phase_next;
            end
            if (s_tready)
            begin
                s1_valid_reg <= accept;
            end
            if (out_ready)
            begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_d_reg   <= d_wide[DW-1:0];
            s1_neg_reg <= neg_next;
        end
        if (out_ready && s1_valid_reg)
        begin
            m_data_reg <= sample_next;
        end
    end

    assign prod = PRODW'(s1_d_reg) * PRODW'(AMP);

    always_comb
    begin
        case (waveform_reg)
            WAVE_SINE:   mag = rom_data;
            WAVE_SQUARE: mag = AMP;
            default:     mag = prod[PW+MAG_W-1:PW];
        endcase
    end

    assign mag_s       = {1'b0, mag};
    assign sample_next = s1_neg_reg ? -mag_s : mag_s;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    `MWO_ASSERT(a_restart_phase, (accept && s_tdata[0]) |=> (phase_acc_reg == $past(step_aligned)), "restart did not reload phase with one step")
    `MWO_ASSERT(a_accept_fills_s1, accept |=> s1_valid_reg, "accepted beat did not reach the middle stage")
    `MWO_ASSERT(a_s1_holds, (s1_valid_reg && !out_ready) |=> (s1_valid_reg && $stable(s1_d_reg)), "middle stage lost a beat under stall")
    `MWO_ASSERT(a_sample_range, m_tvalid |-> (($signed(m_tdata) <= 16'sd30000) && ($signed(m_tdata) >= -16'sd30000)), "sample out of range")
    `MWO_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!m_valid_reg && !s1_valid_reg), "pipeline valid set during reset")

endmodule
